// File: hw/rtl/bsa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsa_pkg: shared types and constants for the bitmap slot allocator
// Request and response payloads, status codes and sizing constants.
// ---------------------------------------------------------------------------
package bsa_pkg;

   // sizing
   localparam int SLOTS_PER_GROUP = 16;
   localparam int NUM_GROUPS      = 64;
   localparam int GROUP_W         = 6;
   localparam int SLOT_W          = 4;
   localparam int CFG_W           = 7;
   localparam int GROUP_IDX_W     = $clog2(NUM_GROUPS);

   // active group count after reset
   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(64);

   // request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_SUCCESS = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_UNKNOWN = 2'd2
   } status_type;

   typedef struct packed {
      logic              command;
      logic [GROUP_W-1:0] group_in;
      logic [SLOT_W-1:0]  slot_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [GROUP_W-1:0] group_out;
      logic [SLOT_W-1:0]  slot_out;
   } rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/bsa_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsa_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_slot_allocator_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_slot_allocator_core: first-fit slot allocator over group bitmaps
// Allocate takes the lowest free slot of the first active group with room;
// free clears a named slot of an active group.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one request: allocate
//   or free of a group/slot. rsp channel returns exactly one response per
//   request with status, group and slot. csr channel writes active_groups;
//   it is always ready and should only be written while the block is idle.
// Sequence:
//   req_ready returns in the same cycle in which rsp_valid rises when the
//   output register is free. An allocate reads groups in order from group 0
//   and stops at the first one with room; a scan over full groups runs up to
//   active_groups. The occupancy ram is scanned one group per cycle through
//   its single registered read port. A free reads, modifies and writes back,
//   then responds; an unknown group responds without a ram access.
//   One request is in work at a time; req_ready is high only when idle.
// Reset:
//   synchronous active high reset clears all per-group valid bits, so every
//   slot reads as free; active_groups returns to 64.
// Stall:
//   a held response sits in the output register; the next request is still
//   accepted and its result waits in a hold state until the output drains.
// ---------------------------------------------------------------------------
module bitmap_slot_allocator_core
   import bsa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_WR,
      ST_HOLD
   } state_type;

   localparam logic [SLOTS_PER_GROUP-1:0] FULL_MAP = '1;
   localparam logic [CFG_W-1:0]           MAX_ACTIVE = CFG_W'(NUM_GROUPS);

   state_type                  state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;
   rsp_type                    res_ff, res_in;
   req_type                    req_ff, req_in;
   logic [CFG_W-1:0]           active_ff, active_in;
   logic [CFG_W-1:0]           issue_ff, issue_in;
   logic [CFG_W-1:0]           chk_ff, chk_in;
   logic                       pend_ff, pend_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [NUM_GROUPS-1:0]      valid_ff, valid_in;

   logic [CFG_W-1:0]           eff_active;
   logic                       ram_wr_en;
   logic [GROUP_IDX_W-1:0]     ram_wr_addr;
   logic [SLOTS_PER_GROUP-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [GROUP_IDX_W-1:0]     ram_rd_addr;
   logic [SLOTS_PER_GROUP-1:0] ram_rd_data;
   logic [SLOTS_PER_GROUP-1:0] cur_map;
   logic [SLOT_W-1:0]          free_slot;

   // occupancy bitmaps
   bsa_ram #(
      .WIDTH(SLOTS_PER_GROUP),
      .DEPTH(NUM_GROUPS)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // clamp active count to the number of groups
   assign eff_active = (active_ff > MAX_ACTIVE) ? MAX_ACTIVE : active_ff;

   // entry never written reads as all free
   assign cur_map = rd_vld_ff ? ram_rd_data : '0;

   // lowest clear bit of the current bitmap
   always_comb begin
      free_slot = '0;
      for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
         if (!cur_map[s]) begin
            free_slot = SLOT_W'(s);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      req_in       = req_ff;
      active_in    = active_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      pend_in      = pend_ff;
      rd_vld_in    = rd_vld_ff;
      valid_in     = valid_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = chk_ff[GROUP_IDX_W-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[GROUP_IDX_W-1:0];

      // output register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration write
      if (csr_valid) begin
         active_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.command == CMD_FREE) begin
                  if ({1'b0, req_data.group_in} >= eff_active) begin
                     res_in   = '{status: STATUS_UNKNOWN, group_out: '0, slot_out: '0};
                     state_in = ST_HOLD;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_data.group_in[GROUP_IDX_W-1:0];
                     state_in    = ST_FREE_WR;
                  end
               end else begin
                  issue_in = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff && (cur_map != FULL_MAP)) begin
               // first group with room: take the slot
               ram_wr_en   = 1'b1;
               ram_wr_addr = chk_ff[GROUP_IDX_W-1:0];
               ram_wr_data = cur_map | (SLOTS_PER_GROUP'(1) << free_slot);
               valid_in[chk_ff[GROUP_IDX_W-1:0]] = 1'b1;
               res_in   = '{status: STATUS_SUCCESS, group_out: GROUP_W'(chk_ff),
                            slot_out: free_slot};
               state_in = ST_HOLD;
            end else if (!pend_ff && (issue_ff >= eff_active)) begin
               // every active group checked and full
               res_in   = '{status: STATUS_FULL, group_out: '0, slot_out: '0};
               state_in = ST_HOLD;
            end else begin
               // read next group while checking the previous one
               ram_rd_en   = (issue_ff < eff_active);
               ram_rd_addr = issue_ff[GROUP_IDX_W-1:0];
               chk_in      = issue_ff;
               pend_in     = ram_rd_en;
               if (ram_rd_en) begin
                  issue_in = issue_ff + CFG_W'(1);
               end
            end
         end
         ST_FREE_WR: begin
            if (int'(req_ff.slot_in) < SLOTS_PER_GROUP) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = req_ff.group_in[GROUP_IDX_W-1:0];
               ram_wr_data = cur_map & ~(SLOTS_PER_GROUP'(1) << req_ff.slot_in);
               valid_in[req_ff.group_in[GROUP_IDX_W-1:0]] = 1'b1;
            end
            res_in   = '{status: STATUS_SUCCESS, group_out: '0, slot_out: '0};
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // valid bit travels with the ram read
      if (ram_rd_en) begin
         rd_vld_in = valid_ff[ram_rd_addr];
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_RESET;
         pend_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      req_ff      <= req_in;
      issue_ff    <= issue_in;
      chk_ff      <= chk_in;
   end

`ifndef ASSERT_OFF
   // ram is written only while scanning or finishing a free
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_SCAN || state_ff == ST_FREE_WR))
      else $error("occupancy write outside scan or free");

   // a checked group is always inside the active range
   a_chk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff) |-> (chk_ff < eff_active))
      else $error("scan checked a group outside the active range");

   // an accepted request leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // failed responses carry zero group and slot
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STATUS_SUCCESS) |->
         (rsp_data_ff.group_out == '0 && rsp_data_ff.slot_out == '0))
      else $error("error response with nonzero group or slot");
`endif

endmodule
`default_nettype wire

// File: dv/bsa_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsa_checker: response predictor and scoreboard for the slot allocator
// Watches the request, response and csr channels, keeps its own copy of the
// group bitmaps and the active group count, predicts one response per
// accepted request and compares every accepted response with the oldest one.
// ---------------------------------------------------------------------------
module bsa_checker
   import bsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data,
   output int               error_count,
   output int               pending_count
);

   // predicted group bitmaps, one bit per slot, set when taken
   logic [SLOTS_PER_GROUP-1:0] slot_map [NUM_GROUPS];
   logic [CFG_W-1:0]           group_limit;
   rsp_type                    expected_rsp_q [$];
   int                         mismatch_total = 0;

   // first-fit allocate or release, updates the bitmaps like the block does
   function automatic rsp_type apply_slot_request(req_type r);
      rsp_type     res;
      int unsigned live;
      bit          found;
      res.status    = STATUS_SUCCESS;
      res.group_out = '0;
      res.slot_out  = '0;
      found         = 1'b0;
      live          = (group_limit > NUM_GROUPS) ? NUM_GROUPS : group_limit;
      if (r.command == CMD_ALLOC) begin
         res.status = STATUS_FULL;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            if (!found && g < live && slot_map[g] != '1) begin
               for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
                  if (!found && !slot_map[g][s]) begin
                     slot_map[g][s] = 1'b1;
                     found          = 1'b1;
                     res.status     = STATUS_SUCCESS;
                     res.group_out  = GROUP_W'(g);
                     res.slot_out   = SLOT_W'(s);
                  end
               end
            end
         end
      end else if (r.group_in >= live) begin
         res.status = STATUS_UNKNOWN;
      end else if (r.slot_in < SLOTS_PER_GROUP) begin
         // releasing a slot that is already free just clears it again
         slot_map[r.group_in][r.slot_in] = 1'b0;
      end
      return res;
   endfunction

   // sample all three channels at the clock edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) slot_map[g] = '0;
         group_limit = ACTIVE_RESET;
         expected_rsp_q.delete();
      end else begin
         // response side first: it can never belong to a request taken now
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding: status %0d group %0d slot %0d",
                      rsp_data.status, rsp_data.group_out, rsp_data.slot_out);
               mismatch_total++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatch_total++;
               end
               if (rsp_data.group_out !== want.group_out) begin
                  $error("group_out: expected %0d, got %0d", want.group_out,
                         rsp_data.group_out);
                  mismatch_total++;
               end
               if (rsp_data.slot_out !== want.slot_out) begin
                  $error("slot_out: expected %0d, got %0d", want.slot_out, rsp_data.slot_out);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(apply_slot_request(req_data));
         if (csr_valid && csr_ready) group_limit = csr_data;
      end
      error_count   <= mismatch_total;
      pending_count <= expected_rsp_q.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench top for bitmap_slot_allocator_core
// Drives allocate and free requests and active group count writes with
// random idle and stall patterns; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
   import bsa_pkg::*;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   int error_count;
   int pending_count;

   // idle rates in percent, long response hold-off handshake
   int send_idle_pct  = 21;
   int rsp_stall_pct  = 71;
   int hold_asked     = 0;
   int hold_done      = 0;
   int cur_active     = 64;

   bitmap_slot_allocator_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   bsa_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

   // response side: random stalls, plus a long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_done != hold_asked) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_done++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // offer one request, hold it until taken, then maybe idle
   task automatic send_request(input logic cmd, input logic [GROUP_W-1:0] grp,
                               input logic [SLOT_W-1:0] slt);
      req_type r;
      r.command  = cmd;
      r.group_in = grp;
      r.slot_in  = slt;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   // stop offering until every outstanding request has its response
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // active group count write, only with the block idle
   task automatic write_active(input int value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      cur_active = value;
   endtask

   // random request, mostly allocates, groups often aimed where allocations land
   task automatic send_random_request();
      int          live;
      logic        cmd;
      logic [GROUP_W-1:0] grp;
      live = (cur_active > NUM_GROUPS) ? NUM_GROUPS : cur_active;
      cmd  = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
      if (live == 0 || $urandom_range(0, 99) < 10)
         grp = GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
      else if ($urandom_range(0, 1) == 0)
         grp = GROUP_W'($urandom_range(0, live - 1));
      else
         grp = GROUP_W'($urandom_range(0, (live > 4) ? 3 : live - 1));
      send_request(cmd, grp, SLOT_W'($urandom_range(0, SLOTS_PER_GROUP - 1)));
   endtask

   // stimulus and verdict
   initial begin
      int phase_active [9] = '{2, 64, 5, 1, 127, 3, 0, 64, 2};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: releasing free slots, first-fit order, extremes of fields
      send_request(CMD_FREE, 6'd63, 4'd15);
      send_request(CMD_FREE, 6'd0, 4'd0);
      repeat (3) send_request(CMD_ALLOC, 6'd0, 4'd0);
      send_request(CMD_FREE, 6'd0, 4'd1);
      send_request(CMD_ALLOC, 6'd63, 4'd15);

      // one active group: fill it, then full and unknown group
      write_active(1);
      repeat (13) send_request(CMD_ALLOC, 6'd0, 4'd0);
      send_request(CMD_ALLOC, 6'd0, 4'd0);
      send_request(CMD_FREE, 6'd1, 4'd3);
      send_request(CMD_FREE, 6'd63, 4'd0);

      // no active group at all
      write_active(0);
      send_request(CMD_ALLOC, 6'd0, 4'd0);
      send_request(CMD_FREE, 6'd0, 4'd0);

      // count above the group range, group 0 still full
      write_active(127);
      send_request(CMD_ALLOC, 6'd0, 4'd0);

      // random phases over several counts and idle patterns
      for (int p = 0; p < 9; p++) begin
         write_active(phase_active[p]);
         case (p / 3)
            0: begin
               send_idle_pct = 21;
               rsp_stall_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               rsp_stall_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int i = 0; i < 150; i++) begin
            if ((p == 1 || p == 7) && i == 30) hold_asked++;
            if ((p == 4 || p == 8) && i == 75) drain_results();
            send_random_request();
         end
      end

      drain_results();
      repeat (80) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
